### hw/rtl/mrrs_pkg.sv
// Shared types and constants for the motor ramp and reversal sequencer.
package mrrs_pkg;

    localparam int unsigned DUTY_W     = 8;
    localparam int unsigned INTERVAL_W = 10;
    localparam int unsigned WAIT_W     = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [1:0] CMD_TICK      = 2'd0;
    localparam logic [1:0] CMD_SET_SPEED = 2'd1;
    localparam logic [1:0] CMD_DIRECTION = 2'd2;

    localparam logic [1:0] DIR_STOPPED   = 2'd0;
    localparam logic [1:0] DIR_CW        = 2'd1;
    localparam logic [1:0] DIR_CCW       = 2'd2;
    localparam logic [1:0] DIR_INVALID   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_WAIT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_WAIT   = 2'd2;

    localparam logic [INTERVAL_W-1:0] RAMP_INTERVAL_RESET = 10'd15;
    localparam logic [WAIT_W-1:0]     STOP_WAIT_RESET     = 16'd1000;
    localparam logic [WAIT_W-1:0]     SETTLE_WAIT_RESET   = 16'd200;
    localparam logic [DUTY_W-1:0]     TARGET_DUTY_RESET   = 8'd120;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [DUTY_W-1:0] speed;
        logic [1:0]        direction;
    } t_in_item;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              dir_pin;
        logic              enable;
        logic              busy_res;
        logic [1:0]        active_direction;
    } t_out_item;

endpackage

### hw/rtl/mrrs_core.sv
// Sequencer state, configuration registers and the single-pass next-state logic.
module mrrs_core
    import mrrs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_accept,
    input  t_in_item              i_item,
    output t_out_item             o_result
);

    typedef enum logic [1:0] {
        PH_NORMAL,
        PH_DOWN,
        PH_STOP,
        PH_SETTLE
    } t_phase;

    logic [INTERVAL_W-1:0] r_ramp_interval;
    logic [WAIT_W-1:0]     r_stop_wait;
    logic [WAIT_W-1:0]     r_settle_wait;

    logic [DUTY_W-1:0] r_duty, n_duty;
    logic [DUTY_W-1:0] r_target, n_target;
    logic [1:0]        r_cur_dir, n_cur_dir;
    logic [1:0]        r_pend_dir, n_pend_dir;
    t_phase            r_phase, n_phase;
    logic [WAIT_W-1:0] r_tick, n_tick;
    logic              r_dir_level, n_dir_level;
    logic              r_enable, n_enable;

    logic [DUTY_W-1:0] goal;
    logic [WAIT_W-1:0] tick_inc;
    logic [WAIT_W-1:0] interval_ext;

    assign tick_inc     = r_tick + WAIT_W'(1);
    assign interval_ext = WAIT_W'(r_ramp_interval);
    assign goal         = (r_phase == PH_NORMAL) ? r_target : '0;

    always_comb begin
        n_duty      = r_duty;
        n_target    = r_target;
        n_cur_dir   = r_cur_dir;
        n_pend_dir  = r_pend_dir;
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_dir_level = r_dir_level;
        n_enable    = r_enable;
        case (i_item.cmd)
            CMD_TICK: begin
                case (r_phase)
                    PH_NORMAL, PH_DOWN: begin
                        if (r_duty == goal) begin
                            n_tick = '0;
                        end else if (tick_inc >= interval_ext) begin
                            n_tick = '0;
                            n_duty = (r_duty < goal) ? r_duty + DUTY_W'(1)
                                                     : r_duty - DUTY_W'(1);
                        end else begin
                            n_tick = tick_inc;
                        end
                        // Ramp-down ends on the first tick that leaves the duty at zero.
                        if (r_phase == PH_DOWN && n_duty == '0) begin
                            n_phase  = PH_STOP;
                            n_enable = 1'b0;
                            n_tick   = '0;
                        end
                    end
                    PH_STOP: begin
                        n_tick = tick_inc;
                        if (tick_inc >= r_stop_wait) begin
                            n_cur_dir   = r_pend_dir;
                            n_dir_level = (r_pend_dir == DIR_CW);
                            n_enable    = 1'b1;
                            n_phase     = PH_SETTLE;
                            n_tick      = '0;
                        end
                    end
                    default: begin
                        n_tick = tick_inc;
                        if (tick_inc >= r_settle_wait) begin
                            n_tick  = '0;
                            n_phase = (r_pend_dir != r_cur_dir) ? PH_DOWN : PH_NORMAL;
                        end
                    end
                endcase
            end
            CMD_SET_SPEED: begin
                n_target = i_item.speed;
            end
            CMD_DIRECTION: begin
                if (i_item.direction != DIR_INVALID) begin
                    if (r_phase == PH_NORMAL) begin
                        if (i_item.direction != r_cur_dir) begin
                            n_pend_dir = i_item.direction;
                            n_phase    = PH_DOWN;
                            n_tick     = '0;
                        end
                    end else begin
                        n_pend_dir = i_item.direction;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_result.duty             = n_duty;
        o_result.dir_pin          = n_dir_level;
        o_result.enable           = n_enable;
        o_result.busy_res         = (n_phase != PH_NORMAL);
        o_result.active_direction = n_cur_dir;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_interval <= RAMP_INTERVAL_RESET;
            r_stop_wait     <= STOP_WAIT_RESET;
            r_settle_wait   <= SETTLE_WAIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RAMP_INTERVAL: r_ramp_interval <= i_cfg_data[INTERVAL_W-1:0];
                CFG_STOP_WAIT:     r_stop_wait     <= i_cfg_data[WAIT_W-1:0];
                CFG_SETTLE_WAIT:   r_settle_wait   <= i_cfg_data[WAIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty      <= '0;
            r_target    <= TARGET_DUTY_RESET;
            r_cur_dir   <= DIR_STOPPED;
            r_pend_dir  <= DIR_STOPPED;
            r_phase     <= PH_NORMAL;
            r_tick      <= '0;
            r_dir_level <= 1'b0;
            r_enable    <= 1'b1;
        end else if (i_accept) begin
            r_duty      <= n_duty;
            r_target    <= n_target;
            r_cur_dir   <= n_cur_dir;
            r_pend_dir  <= n_pend_dir;
            r_phase     <= n_phase;
            r_tick      <= n_tick;
            r_dir_level <= n_dir_level;
            r_enable    <= n_enable;
        end
    end

endmodule

### hw/rtl/mrrs_out_buf.sv
// Result register with a skid entry, so a stalled result does not block the input side.
module mrrs_out_buf
    import mrrs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_result,
    output logic      o_full,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic      r_out_valid;
    logic      r_skid_valid;
    t_out_item r_out;
    t_out_item r_skid;
    logic      take;

    assign take        = r_out_valid && !i_out_stall;
    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_push) begin
                // The input side only pushes while the skid entry is empty.
                if (!r_out_valid || take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (take) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (!r_out_valid || take) begin
                r_out <= i_result;
            end else begin
                r_skid <= i_result;
            end
        end else if (take && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

endmodule

### hw/rtl/motor_ramp_reversal_sequencer_unit.sv
// Each accepted item's result is registered in the output register, or in the one-entry
// skid when the output stalls. Throughput: one transaction per cycle while the skid is
// empty; the next-state logic and state registers settle each item in a single pass.
// Reset is synchronous and active low: it restores the configuration defaults and the
// idle sequencer state, and empties the result buffer.
module motor_ramp_reversal_sequencer_unit
    import mrrs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data
);

    logic      accept;
    logic      buf_full;
    t_out_item result;

    assign o_in_stall = buf_full;
    assign accept     = i_in_valid && !buf_full;

    mrrs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_item      (i_in_data),
        .o_result    (result)
    );

    mrrs_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_result    (result),
        .o_full      (buf_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // A full skid entry means the result register is occupied too.
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("skid entry holds a result while the output register is empty");

    // Outside a direction change the driver is always enabled.
    a_idle_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.busy_res) |-> o_out_data.enable)
        else $error("driver disabled while no direction change runs");

    // The pin is high only when clockwise is the direction in force.
    a_pin_matches_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.dir_pin) |-> (o_out_data.active_direction == DIR_CW))
        else $error("direction pin high without clockwise direction");

    // An accepted transaction always leaves a result waiting in the next cycle.
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted transaction produced no result");

endmodule
